// ----- hw/rtl/rtem_pkg.sv -----
// ============================================================================
// rtem_pkg
// Shared types, constants and helpers for the exact-match route table engine.
// ============================================================================
package rtem_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IFACE_BYTES = 8;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [31:0] dest;
        logic [5:0]  prefix;
        logic [31:0] gateway;
        logic [63:0] iface;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Keep the name up to its first zero byte, within IFACE_BYTES bytes.
    function automatic logic [63:0] norm_iface(input logic [63:0] name);
        logic [63:0] kept;
        logic        stop;
        kept = '0;
        stop = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (k >= IFACE_BYTES || name[8*k +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                kept[8*k +: 8] = name[8*k +: 8];
            end
        end
        return kept;
    endfunction

endpackage

// ----- hw/rtl/rtem_ram.sv -----
// ============================================================================
// rtem_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module rtem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/rtem_seq.sv -----
// ============================================================================
// rtem_seq
// Command sequencer: inserts at the tail, scans the table for delete and
// update, compacts survivors in place, and produces one status per command.
// ============================================================================
module rtem_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [31:0]       i_dest_ip,
    input  logic [5:0]        i_prefix_len,
    input  logic [31:0]       i_gw_ip,
    input  logic [63:0]       i_out_iface,
    output rtem_pkg::t_ram_req o_ram_req,
    input  rtem_pkg::t_entry  i_ram_rdata,
    output rtem_pkg::t_res    o_res,
    input  logic              i_res_ready
);
    import rtem_pkg::*;

    t_state           r_state, n_state;
    logic [1:0]       r_cmd, n_cmd;
    logic [31:0]      r_dest, n_dest;
    logic [5:0]       r_pfx, n_pfx;
    logic [31:0]      r_gw, n_gw;
    logic [63:0]      r_iface, n_iface;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_w, n_w;
    logic             r_found, n_found;
    logic [1:0]       r_status, n_status;

    logic             hit;
    logic             last;
    t_ram_req         req;

    assign hit  = (i_ram_rdata.dest == r_dest) && (i_ram_rdata.prefix == r_pfx);
    assign last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_w      <= '0;
            r_found  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_w      <= n_w;
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_dest  <= n_dest;
        r_pfx   <= n_pfx;
        r_gw    <= n_gw;
        r_iface <= n_iface;
    end

    // Delete writes slot w while reading slot i+1 with w <= i, and update
    // stops on its write, so reads and writes never collide on one entry.
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_dest   = r_dest;
        n_pfx    = r_pfx;
        n_gw     = r_gw;
        n_iface  = r_iface;
        n_count  = r_count;
        n_idx    = r_idx;
        n_w      = r_w;
        n_found  = r_found;
        n_status = r_status;

        req       = '0;
        req.wdata = i_ram_rdata;

        o_in_ready = 1'b0;
        o_res      = '0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_dest  = i_dest_ip;
                    n_pfx   = i_prefix_len;
                    n_gw    = i_gw_ip;
                    n_iface = norm_iface(i_out_iface);
                    n_idx   = '0;
                    n_w     = '0;
                    n_found = 1'b0;
                    n_state = S_DONE;
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                req.we            = 1'b1;
                                req.waddr         = r_count[IDX_W-1:0];
                                req.wdata.dest    = i_dest_ip;
                                req.wdata.prefix  = i_prefix_len;
                                req.wdata.gateway = i_gw_ip;
                                req.wdata.iface   = norm_iface(i_out_iface);
                                n_count           = r_count + CNT_W'(1);
                                n_status          = ST_OK;
                            end
                        end
                        CMD_DELETE, CMD_UPDATE: begin
                            n_status = ST_NOMATCH;
                            if (r_count != '0) begin
                                req.re  = 1'b1;
                                req.raddr = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_NOMATCH;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_cmd == CMD_DELETE) begin
                    // Drop matches, move survivors down to the write slot.
                    if (hit) begin
                        n_found = 1'b1;
                    end else begin
                        req.we    = 1'b1;
                        req.waddr = r_w[IDX_W-1:0];
                        n_w       = r_w + CNT_W'(1);
                    end
                    if (last) begin
                        n_count  = hit ? r_w : r_w + CNT_W'(1);
                        n_status = (hit || r_found) ? ST_OK : ST_NOMATCH;
                        n_state  = S_DONE;
                    end else begin
                        req.re    = 1'b1;
                        req.raddr = r_idx + IDX_W'(1);
                        n_idx     = r_idx + IDX_W'(1);
                    end
                end else begin
                    if (hit) begin
                        req.we            = 1'b1;
                        req.waddr         = r_idx;
                        req.wdata.gateway = r_gw;
                        req.wdata.iface   = r_iface;
                        n_status          = ST_OK;
                        n_state           = S_DONE;
                    end else if (last) begin
                        n_status = ST_NOMATCH;
                        n_state  = S_DONE;
                    end else begin
                        req.re    = 1'b1;
                        req.raddr = r_idx + IDX_W'(1);
                        n_idx     = r_idx + IDX_W'(1);
                    end
                end
            end

            S_DONE: begin
                o_res.valid  = 1'b1;
                o_res.status = r_status;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ram_req = req;

endmodule

// ----- hw/rtl/route_table_exact_match_engine_core.sv -----
// Insert and unused commands go from acceptance straight to S_DONE; delete and
// update first scan up to the entry count in S_SCAN, reading one RAM entry per cycle.
// From S_DONE the status enters the output register; a new command is taken only in S_IDLE,
// and a status waiting in the output register holds the next one and blocks input.
// Reset: synchronous active-low; clears the entry count and the sequencer,
// no clearing pass, table contents stay undefined until written.
// ============================================================================
// route_table_exact_match_engine_core
// Route table with insert, delete-all-matches with compaction, and update of
// the first match, keyed on destination and prefix length.
// ============================================================================
module route_table_exact_match_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_dest_ip,
    input  logic [5:0]  i_prefix_len,
    input  logic [31:0] i_gw_ip,
    input  logic [63:0] i_out_iface,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status
);
    import rtem_pkg::*;

    t_ram_req   ram_req;
    t_entry     ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    t_res       res;
    logic       res_ready;

    logic       r_out_valid;
    logic [1:0] r_out_status;

    rtem_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_dest_ip    (i_dest_ip),
        .i_prefix_len (i_prefix_len),
        .i_gw_ip      (i_gw_ip),
        .i_out_iface  (i_out_iface),
        .o_ram_req    (ram_req),
        .i_ram_rdata  (ram_rdata),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    rtem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_entry'(ram_rdata_raw);

    // Output register: hold the status until the transaction is taken.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_out_status <= res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Bench for the exact-match route table engine: commands go in through a
// bursty valid/ready driver, a stalling monitor takes the status back, and a
// shadow route table predicts the status of every accepted transaction.
// ============================================================================
module tb_top;

    import rtem_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RDY_ON   = 0;
    localparam int RDY_COIN = 1;
    localparam int RDY_OFF  = 2;

    localparam int N_RANDOM = 1350;
    localparam int N_KEYS   = 6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] dest;
        logic [5:0]  prefix;
        logic [31:0] gw;
        logic [63:0] iface;
    } t_route_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_cmd;
    logic [31:0] i_dest_ip;
    logic [5:0]  i_prefix_len;
    logic [31:0] i_gw_ip;
    logic [63:0] i_out_iface;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;

    t_route_cmd  pending_cmds[$];
    logic [1:0]  status_fifo[$];

    // Shadow of the route table.
    t_entry      route_tbl[TABLE_DEPTH];
    int          route_cnt;

    int          fail_cnt;
    int          burst_left;
    int          gap_left;
    int          rdy_mode;
    int          rdy_left;

    logic [31:0] key_dest[N_KEYS];
    logic [5:0]  key_prefix[N_KEYS];

    route_table_exact_match_engine_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_dest_ip    (i_dest_ip),
        .i_prefix_len (i_prefix_len),
        .i_gw_ip      (i_gw_ip),
        .i_out_iface  (i_out_iface),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Name is cut at the first zero byte and at IFACE_BYTES bytes.
    function automatic logic [63:0] trim_iface(input logic [63:0] raw);
        logic [63:0] name;
        int          k;
        name = '0;
        k = 0;
        while (k < IFACE_BYTES && k < 8 && raw[8*k +: 8] != 8'h00) begin
            name[8*k +: 8] = raw[8*k +: 8];
            k++;
        end
        return name;
    endfunction

    function automatic logic [1:0] apply_route_cmd(input t_route_cmd c);
        logic [1:0] st;
        int         wr;
        st = ST_NOMATCH;
        case (c.cmd)
            CMD_INSERT: begin
                if (route_cnt >= TABLE_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    route_tbl[route_cnt] = '{dest: c.dest, prefix: c.prefix, gateway: c.gw,
                                             iface: trim_iface(c.iface)};
                    route_cnt++;
                    st = ST_OK;
                end
            end
            CMD_DELETE: begin
                wr = 0;
                for (int i = 0; i < route_cnt; i++) begin
                    if (route_tbl[i].dest == c.dest && route_tbl[i].prefix == c.prefix) begin
                        st = ST_OK;
                    end else begin
                        route_tbl[wr] = route_tbl[i];
                        wr++;
                    end
                end
                route_cnt = wr;
            end
            CMD_UPDATE: begin
                for (int i = 0; i < route_cnt; i++) begin
                    if (st != ST_OK && route_tbl[i].dest == c.dest &&
                        route_tbl[i].prefix == c.prefix) begin
                        route_tbl[i].gateway = c.gw;
                        route_tbl[i].iface   = trim_iface(c.iface);
                        st = ST_OK;
                    end
                end
            end
            default: st = ST_NOMATCH;
        endcase
        return st;
    endfunction

    task automatic push_cmd(input logic [1:0] cmd, input logic [31:0] dest,
                            input logic [5:0] prefix, input logic [31:0] gw,
                            input logic [63:0] iface);
        pending_cmds.push_back('{cmd: cmd, dest: dest, prefix: prefix, gw: gw, iface: iface});
    endtask

    function automatic logic [63:0] rand_iface();
        logic [63:0] v;
        if ($urandom_range(0, 3) == 0) begin
            v = {$urandom, $urandom};
        end else begin
            for (int k = 0; k < 8; k++) begin
                v[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            end
        end
        return v;
    endfunction

    // Driver: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin : drv
        t_route_cmd nxt;
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_cmd        <= '0;
            i_dest_ip    <= '0;
            i_prefix_len <= '0;
            i_gw_ip      <= '0;
            i_out_iface  <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                status_fifo.push_back(apply_route_cmd('{cmd: i_cmd, dest: i_dest_ip,
                    prefix: i_prefix_len, gw: i_gw_ip, iface: i_out_iface}));
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the transaction until it is taken
            end else if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                nxt = pending_cmds.pop_front();
                i_cmd        <= nxt.cmd;
                i_dest_ip    <= nxt.dest;
                i_prefix_len <= nxt.prefix;
                i_gw_ip      <= nxt.gw;
                i_out_iface  <= nxt.iface;
                i_in_valid   <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: phases of always ready, coin-flip ready and full stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rdy_mode    <= RDY_ON;
            rdy_left    <= 0;
        end else begin
            if (rdy_left == 0) begin
                rdy_mode <= $urandom_range(0, 2);
                rdy_left <= $urandom_range(1, 40);
            end else begin
                rdy_left <= rdy_left - 1;
            end
            case (rdy_mode)
                RDY_ON:   i_out_ready <= 1'b1;
                RDY_COIN: i_out_ready <= 1'($urandom_range(0, 1));
                default:  i_out_ready <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin : mon
        logic [1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_fifo.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("[%0t] unexpected status %0d with nothing pending", $realtime,
                             o_status);
                end
            end else begin
                want = status_fifo.pop_front();
                if (o_status !== want) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("[%0t] status mismatch: expected %0d, got %0d", $realtime,
                                 want, o_status);
                    end
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          ins_w;
        int          r;
        int          kidx;
        logic [1:0]  cmd;
        logic [31:0] dest;
        logic [5:0]  prefix;

        fail_cnt   = 0;
        route_cnt  = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_cmd      = '0;
        i_dest_ip  = '0;
        i_prefix_len = '0;
        i_gw_ip    = '0;
        i_out_iface = '0;
        i_out_ready = 1'b0;

        // Directed: empty table, unused code, key extremes, fill to full, compaction.
        push_cmd(CMD_DELETE, 32'h0, 6'd0, 32'h0, 64'h0);
        push_cmd(CMD_UPDATE, 32'h0, 6'd0, 32'h0, 64'h0);
        push_cmd(CMD_UNUSED, 32'h0, 6'd0, 32'h0, 64'h0);
        push_cmd(CMD_INSERT, 32'h0, 6'd0, 32'h0, 64'h0);
        push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h0102_0304, 64'hAB00_0000_3068_7465);
        push_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 6'd32, 32'h0A0A_0A01, 64'h0000_0000_0000_0031);
        push_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 6'd31, 32'h0A0A_0A01, 64'h0);
        for (int i = 0; i < 13; i++) begin
            if (i % 3 == 0) begin
                push_cmd(CMD_INSERT, 32'h0A00_0001, 6'd24, $urandom, rand_iface());
            end else begin
                push_cmd(CMD_INSERT, $urandom, 6'($urandom_range(0, 63)), $urandom,
                         rand_iface());
            end
        end
        push_cmd(CMD_INSERT, 32'h0A00_0001, 6'd24, 32'h1, 64'h1);
        push_cmd(CMD_UPDATE, 32'h0A00_0001, 6'd24, 32'hC0A8_0001, 64'h0000_3176_6C77);
        push_cmd(CMD_DELETE, 32'h0A00_0001, 6'd24, 32'h0, 64'h0);
        push_cmd(CMD_DELETE, 32'h0A00_0001, 6'd24, 32'h0, 64'h0);
        push_cmd(CMD_INSERT, 32'h0A00_0001, 6'd25, 32'h2, 64'h2);
        push_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

        // Small key pool: pairs share a destination so only the prefix tells them apart.
        for (int k = 0; k < N_KEYS; k += 2) begin
            key_dest[k]     = $urandom;
            key_dest[k + 1] = key_dest[k];
            key_prefix[k]   = 6'($urandom_range(0, 32));
            key_prefix[k + 1] = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(33, 63))
                                                            : key_prefix[k] ^ 6'd1;
        end

        ins_w = 50;
        for (int n = 0; n < N_RANDOM; n++) begin
            // shift the insert/remove balance so the table swings between empty and full
            if (n % 150 == 0) begin
                ins_w = $urandom_range(30, 75);
            end
            r = $urandom_range(0, 99);
            if (r < ins_w) begin
                cmd = CMD_INSERT;
            end else if (r < ins_w + (100 - ins_w) / 2) begin
                cmd = CMD_DELETE;
            end else if (r < 97) begin
                cmd = CMD_UPDATE;
            end else begin
                cmd = CMD_UNUSED;
            end
            if ($urandom_range(0, 9) < 8) begin
                kidx   = $urandom_range(0, N_KEYS - 1);
                dest   = key_dest[kidx];
                prefix = key_prefix[kidx];
            end else begin
                dest   = $urandom;
                prefix = 6'($urandom_range(0, 63));
            end
            push_cmd(cmd, dest, prefix, $urandom, rand_iface());
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (status_fifo.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- route_table_exact_match_engine_core.f -----
hw/rtl/rtem_pkg.sv
hw/rtl/rtem_ram.sv
hw/rtl/rtem_seq.sv
hw/rtl/route_table_exact_match_engine_core.sv
bench/tb_top.sv
